// ===== hw/rtl/sctp_pkg.sv =====
// Shared types and constants for the S-curve trajectory planner core.
// No dependencies; imported by sctp_div and the top level.
`timescale 1ns / 1ps

package sctp_pkg;

	localparam int FIELD_W = 32;
	localparam int RATE_W  = 31;
	localparam int DEN_W   = FIELD_W + 1;
	localparam int ALPHA_W = 25;
	localparam int FRAC_W  = 24;

	localparam logic REG_SLEW_RATE     = 1'b0;
	localparam logic REG_TIME_CONSTANT = 1'b1;

	typedef struct packed {
		logic               start;
		logic [FIELD_W-1:0] dt;
		logic [DEN_W-1:0]   den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic [ALPHA_W-1:0] quot;
	} div_rsp_t;

endpackage

// ===== hw/rtl/sctp_div.sv =====
// Bit-serial restoring divider that forms alpha = dt * 2^24 / den, one bit a cycle.
// Depends on sctp_pkg for the request and response structs.
`timescale 1ns / 1ps

module sctp_div
	import sctp_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [4:0]          count_q;
	logic                lsb_q;
	logic [DEN_W:0]      rem_q;
	logic [DEN_W-1:0]    den_q;
	logic [ALPHA_W-1:0]  quot_q;
	logic [DEN_W:0]      trial;
	logic                fits;

	// The numerator is dt shifted up 24 places; only its bit 24 (dt[0]) is
	// brought down in the iterations, all lower numerator bits are zero.
	always_comb begin
		trial = {rem_q[DEN_W-1:0], (count_q == 5'(FRAC_W)) ? lsb_q : 1'b0};
		fits  = (trial >= {1'b0, den_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q  <= 1'b1;
				count_q <= 5'(FRAC_W);
			end else if (busy_q) begin
				if (count_q == 5'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					count_q <= count_q - 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= {3'b000, req.dt[FIELD_W-1:1]};
			lsb_q  <= req.dt[0];
			den_q  <= req.den;
			quot_q <= '0;
		end else if (busy_q) begin
			rem_q  <= fits ? (trial - {1'b0, den_q}) : trial;
			quot_q <= {quot_q[ALPHA_W-2:0], fits};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quot_q;

endmodule

// ===== hw/rtl/s_curve_trajectory_planner_core.sv =====
// S-curve trajectory planner: rate limiter followed by two low-pass stages.
// Depends on sctp_pkg and on the serial divider sctp_div.
`timescale 1ns / 1ps

// How to use this block:
// Input items arrive on in_valid/in_stall with fields action, target and
// step_time. An item is taken when in_valid is high and in_stall is low.
// in_stall stays high while an item is being worked on, so one item is in
// the block at a time. Results leave on out_valid/out_stall with the field
// smoothed; the result sits in an output register, so a new item may be
// taken while the previous result still waits for the receiver. If the
// receiver stalls while the next result is ready, the block holds that
// result internally and keeps in_stall high until the output frees up.
// Sequencing: a clear item or an item with zero step_time goes straight
// to the finish state, which raises out_valid and returns to idle once
// the output is free. A normal step item passes the multiply, ramp and
// divider-wait states, a multiply and an add state per filter stage, and
// the finish state; it waits for the 25 iterations of the serial divider
// that forms alpha, which runs alongside the ramp step, and makes three
// passes through the one shared multiplier. Items do not overlap.
// Configuration is written through wr_en/wr_index/wr_data while idle.
// Reset sets the rate limit to 1.0 per second, the time constant to zero,
// and clears the ramp and both filter stages.

module s_curve_trajectory_planner_core
	import sctp_pkg::*;
#(
	parameter int VALUE_WIDTH = 32
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      wr_en,
	input  logic                      wr_index,
	input  logic [FIELD_W-1:0]        wr_data,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      action,
	input  logic signed [FIELD_W-1:0] target,
	input  logic [FIELD_W-1:0]        step_time,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic signed [FIELD_W-1:0] smoothed
);

	// Saturation range; widths above the field width act as the field width.
	localparam int VW = (VALUE_WIDTH > FIELD_W) ? FIELD_W
		: ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
	localparam logic signed [35:0] VMAX = (36'sd1 <<< (VW - 1)) - 36'sd1;
	localparam logic signed [35:0] VMIN = -VMAX - 36'sd1;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_MUL_STEP = 4'd1;
	localparam logic [3:0] ST_RAMP     = 4'd2;
	localparam logic [3:0] ST_DIV_WAIT = 4'd3;
	localparam logic [3:0] ST_LP1_MUL  = 4'd4;
	localparam logic [3:0] ST_LP1_ADD  = 4'd5;
	localparam logic [3:0] ST_LP2_MUL  = 4'd6;
	localparam logic [3:0] ST_LP2_ADD  = 4'd7;
	localparam logic [3:0] ST_FINISH   = 4'd8;

	function automatic logic signed [FIELD_W-1:0] sat_v(input logic signed [35:0] x);
		logic signed [35:0] y;
		y = x;
		if (x > VMAX) y = VMAX;
		else if (x < VMIN) y = VMIN;
		return y[FIELD_W-1:0];
	endfunction

	logic [3:0]                state_q;
	logic [RATE_W-1:0]         slew_rate_q;
	logic [FIELD_W-1:0]        time_constant_q;
	logic signed [FIELD_W-1:0] ramp_q;
	logic signed [FIELD_W-1:0] stage_one_q;
	logic signed [FIELD_W-1:0] stage_two_q;
	logic signed [FIELD_W-1:0] target_q;
	logic [FIELD_W-1:0]        dt_q;
	logic [ALPHA_W-1:0]        alpha_q;
	logic signed [FIELD_W-1:0] result_q;
	logic signed [FIELD_W-1:0] smoothed_q;
	logic                      out_valid_q;
	logic signed [66:0]        prod_q;

	logic                      in_take;
	logic                      out_free;
	div_req_t                  div_req;
	div_rsp_t                  div_rsp;

	logic signed [33:0]        mul_a;
	logic [FIELD_W-1:0]        mul_b;
	logic signed [66:0]        mul_p;

	logic [FIELD_W-1:0]        step_amt;
	logic signed [35:0]        ramp_hi;
	logic signed [35:0]        ramp_lo;
	logic signed [35:0]        ramped;
	logic signed [35:0]        lp_sum;
	logic signed [FIELD_W-1:0] lp_base;

	assign in_take  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	// Divider starts at acceptance and overlaps the ramp step.
	assign div_req.start = in_take && !action && (step_time != '0);
	assign div_req.dt    = step_time;
	assign div_req.den   = {1'b0, time_constant_q} + {1'b0, step_time};

	sctp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Shared multiplier: rate times time, then alpha times each stage error.
	always_comb begin
		unique case (state_q)
			ST_MUL_STEP: begin
				mul_a = {3'b000, slew_rate_q};
				mul_b = dt_q;
			end
			ST_LP1_MUL: begin
				mul_a = 34'(ramp_q) - 34'(stage_one_q);
				mul_b = {{(FIELD_W - ALPHA_W){1'b0}}, alpha_q};
			end
			ST_LP2_MUL: begin
				mul_a = 34'(stage_one_q) - 34'(stage_two_q);
				mul_b = {{(FIELD_W - ALPHA_W){1'b0}}, alpha_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
		mul_p = mul_a * $signed({1'b0, mul_b});
	end

	// Ramp bound: the step is capped at 32 bits, then the target is clamped.
	always_comb begin
		step_amt = (|prod_q[62:56]) ? '1 : prod_q[55:24];
		ramp_hi  = 36'(ramp_q) + $signed({4'b0000, step_amt});
		ramp_lo  = 36'(ramp_q) - $signed({4'b0000, step_amt});
		ramped   = 36'(target_q);
		if (36'(target_q) > ramp_hi) ramped = ramp_hi;
		else if (36'(target_q) < ramp_lo) ramped = ramp_lo;
		// The arithmetic shift of the product rounds toward minus infinity.
		lp_base = (state_q == ST_LP1_ADD) ? stage_one_q : stage_two_q;
		lp_sum  = 36'(lp_base) + 36'($signed(prod_q[58:24]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			slew_rate_q     <= 31'd65536;
			time_constant_q <= '0;
			ramp_q          <= '0;
			stage_one_q     <= '0;
			stage_two_q     <= '0;
			out_valid_q     <= 1'b0;
		end else begin
			if (wr_en) begin
				unique case (wr_index)
					REG_SLEW_RATE:     slew_rate_q <= wr_data[RATE_W-1:0];
					REG_TIME_CONSTANT: time_constant_q <= wr_data;
					default:           ;
				endcase
			end

			if (state_q == ST_FINISH && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (action) begin
							ramp_q      <= '0;
							stage_one_q <= '0;
							stage_two_q <= '0;
							state_q     <= ST_FINISH;
						end else if (step_time == '0) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_MUL_STEP;
						end
					end
				end
				ST_MUL_STEP: state_q <= ST_RAMP;
				ST_RAMP: begin
					ramp_q  <= sat_v(ramped);
					state_q <= ST_DIV_WAIT;
				end
				ST_DIV_WAIT: begin
					if (div_rsp.done) state_q <= ST_LP1_MUL;
				end
				ST_LP1_MUL: state_q <= ST_LP1_ADD;
				ST_LP1_ADD: begin
					stage_one_q <= sat_v(lp_sum);
					state_q     <= ST_LP2_MUL;
				end
				ST_LP2_MUL: state_q <= ST_LP2_ADD;
				ST_LP2_ADD: begin
					stage_two_q <= sat_v(lp_sum);
					state_q     <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (in_take) begin
			target_q <= sat_v(36'(target));
			dt_q     <= step_time;
			if (action) result_q <= '0;
			else result_q <= sat_v(36'(target));
		end
		if (state_q == ST_MUL_STEP || state_q == ST_LP1_MUL || state_q == ST_LP2_MUL) begin
			prod_q <= mul_p;
		end
		if (div_rsp.done) alpha_q <= div_rsp.quot;
		if (state_q == ST_LP2_ADD) result_q <= sat_v(lp_sum);
		if (state_q == ST_FINISH && out_free) smoothed_q <= result_q;
	end

	assign out_valid = out_valid_q;
	assign smoothed  = smoothed_q;

	// A clear item leaves the ramp and both filter stages at zero.
	a_clear_zeroes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_take && action) |=> (ramp_q == '0 && stage_one_q == '0 && stage_two_q == '0))
		else $error("clear item did not zero the state");

	// Alpha from the divider never exceeds one in Q1.24.
	a_alpha_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (div_rsp.quot <= (ALPHA_W'(1) << FRAC_W)))
		else $error("alpha out of range");

	// The divider finishes only while the sequencer waits for it.
	a_div_in_step: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_DIV_WAIT || state_q == ST_RAMP))
		else $error("divider result arrived outside a step item");

	// A result is loaded only when the output register is free.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH && out_valid_q && out_stall) |=> (state_q == ST_FINISH))
		else $error("result left the sequencer while the output was stalled");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking testbench for the S-curve trajectory planner core.
// Depends on sctp_pkg and s_curve_trajectory_planner_core; reads no files.
`timescale 1ns / 1ps

// How the bench works:
// A directed table runs first. It covers a clear right after reset, the
// extreme targets and step times, an enormous ramp bound that never limits,
// an all-zero rate and a time constant of all ones. Random phases follow. Each
// phase first lets the core drain and then writes a new rate and time
// constant. Within a phase most items steer toward a held goal, so the ramp
// and both lag stages have time to converge. A few clears and one-off noise
// targets are mixed in. A behavioral predictor works out the expected smoothed
// value of every accepted item. The monitor compares each accepted result
// with the oldest expected value.

module tb_top
	import sctp_pkg::*;
();

	localparam int VALUE_WIDTH = 32;

	// The saturation range follows the core's parameter. A width above the
	// 32-bit fields acts as 32.
	localparam int     SAT_W  = (VALUE_WIDTH > 32) ? 32 : ((VALUE_WIDTH < 2) ? 2 : VALUE_WIDTH);
	localparam longint SAT_HI = (longint'(1) << (SAT_W - 1)) - 1;
	localparam longint SAT_LO = -SAT_HI - 1;

	localparam logic ACT_STEP  = 1'b0;
	localparam logic ACT_CLEAR = 1'b1;

	// DRAIN_CYCLES is how long the bench waits after the last result before
	// it calls the core idle.
	localparam int DRAIN_CYCLES    = 64;
	localparam int END_WAIT_LIMIT  = 20000;
	localparam int LIMIT_CYCLES    = 1000000;
	localparam int RANDOM_PHASES   = 10;
	localparam int ITEMS_PER_PHASE = 128;
	localparam int SQUEEZE_PHASE   = 4;
	localparam int SQUEEZE_CYCLES  = 400;
	localparam int PRINT_LIMIT     = 40;
	localparam int PLAN_ROWS       = 25;

	typedef enum logic {ROW_ITEM, ROW_WRITE} row_kind_t;

	// For an item row, sel is the action and span is the step time. For a
	// register write, sel is the register index and span is the written word.
	// When known is set, want is the result that can be read off directly.
	typedef struct packed {
		row_kind_t   kind;
		logic        sel;
		logic [31:0] tgt;
		logic [31:0] span;
		logic        known;
		logic [31:0] want;
	} plan_row_t;

	plan_row_t directed_plan [PLAN_ROWS] = '{
		// Clear straight after reset. The step time is ignored.
		'{ROW_ITEM,  ACT_CLEAR, 32'h1234_5678, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		// With no elapsed time the target passes straight through.
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h7FFF_FFFF},
		'{ROW_ITEM,  ACT_STEP,  32'h8000_0000, 32'h0000_0000, 1'b1, 32'h8000_0000},
		// One second at 1.0 per second, with a zero time constant.
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'h0100_0000, 1'b1, 32'h0001_0000},
		'{ROW_ITEM,  ACT_STEP,  32'h8000_0000, 32'h0100_0000, 1'b1, 32'h0000_0000},
		'{ROW_ITEM,  ACT_STEP,  32'h8000_0000, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
		// At the largest rate the ramp bound lies beyond the value range.
		'{ROW_WRITE, REG_SLEW_RATE,     32'h0, 32'h7FFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF},
		'{ROW_ITEM,  ACT_STEP,  32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
		'{ROW_WRITE, REG_TIME_CONSTANT, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'h0000_0001, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h0000_0000, 32'h0080_0000, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_CLEAR, 32'h0000_0000, 32'h0000_0000, 1'b1, 32'h0000_0000},
		// With a zero rate the ramp never leaves zero.
		'{ROW_WRITE, REG_SLEW_RATE,     32'h0, 32'h0000_0000, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000},
		'{ROW_ITEM,  ACT_STEP,  32'h0000_0001, 32'h0000_0000, 1'b1, 32'h0000_0001},
		'{ROW_WRITE, REG_TIME_CONSTANT, 32'h0, 32'h0000_1000, 1'b0, 32'h0},
		// The top bit of the rate word does not exist in the register.
		'{ROW_WRITE, REG_SLEW_RATE,     32'h0, 32'h8001_0000, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'hDEAD_BEEF, 32'h0010_0000, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h2152_4110, 32'h00AB_CDEF, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_STEP,  32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 32'h0},
		'{ROW_ITEM,  ACT_CLEAR, 32'hFFFF_FFFF, 32'h0000_0000, 1'b1, 32'h0000_0000}
	};

	// Every input of the core starts at a known value. Reset is held low from
	// time zero.
	logic                      clk       = 1'b0;
	logic                      arst_n    = 1'b0;
	logic                      wr_en     = 1'b0;
	logic                      wr_index  = 1'b0;
	logic [FIELD_W-1:0]        wr_data   = '0;
	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      action    = 1'b0;
	logic signed [FIELD_W-1:0] target    = '0;
	logic [FIELD_W-1:0]        step_time = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic signed [FIELD_W-1:0] smoothed;

	// This is the predictor's own copy of the registers and of the filter
	// state, at their reset values.
	logic [RATE_W-1:0]  rate_limit   = 31'd65536;
	logic [FIELD_W-1:0] lag_constant = '0;
	longint             ramp_pos     = 0;
	longint             lag_first    = 0;
	longint             lag_second   = 0;

	logic [31:0] expected_smoothed [$];
	int          fail_count     = 0;
	int          cycle_count    = 0;
	int          results_seen   = 0;
	logic        squeeze_request = 1'b0;
	logic        squeeze_done    = 1'b0;
	int          rx_hold = 0;
	int          rx_calm = 0;
	int          tx_calm = 0;
	logic [31:0] oldest_smoothed;

	s_curve_trajectory_planner_core #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.action   (action),
		.target   (target),
		.step_time(step_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.smoothed (smoothed)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// This is the hard stop in case the handshakes hang.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == LIMIT_CYCLES) begin
			$display("tb_top: errors");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		if (fail_count < PRINT_LIMIT)
			$display("tb_top mismatch @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	function automatic longint clamp_value(input longint x);
		if (x > SAT_HI)
			return SAT_HI;
		if (x < SAT_LO)
			return SAT_LO;
		return x;
	endfunction

	// Moves one first-order stage toward x. The step is rounded toward minus
	// infinity, which is exactly what an arithmetic shift gives.
	function automatic longint lag_update(input longint s, input longint x, input longint alpha);
		longint prod;
		prod = alpha * (x - s);
		return clamp_value(s + (prod >>> FRAC_W));
	endfunction

	// Predicts the smoothed value for one item and advances the state.
	function automatic logic [31:0] shape_item(input logic act, input logic [31:0] tgt,
			input logic [31:0] dt);
		longint      goal;
		longint      hi;
		longint      lo;
		longint      pick;
		longint      alpha;
		logic [63:0] stride;
		logic [63:0] den;
		goal = clamp_value(longint'($signed(tgt)));
		if (act == ACT_CLEAR) begin
			ramp_pos   = 0;
			lag_first  = 0;
			lag_second = 0;
			return 32'h0;
		end
		// With no elapsed time the target passes through and the state is kept.
		if (dt == 32'h0)
			return goal[31:0];
		stride = (64'(rate_limit) * 64'(dt)) >> FRAC_W;
		if (stride > 64'hFFFF_FFFF)
			stride = 64'hFFFF_FFFF;
		hi   = ramp_pos + longint'(stride);
		lo   = ramp_pos - longint'(stride);
		pick = goal;
		if (goal > hi)
			pick = hi;
		else if (goal < lo)
			pick = lo;
		ramp_pos   = clamp_value(pick);
		den        = 64'(lag_constant) + 64'(dt);
		alpha      = longint'((64'(dt) << FRAC_W) / den);
		lag_first  = lag_update(lag_first, ramp_pos, alpha);
		lag_second = lag_update(lag_second, lag_first, alpha);
		return lag_second[31:0];
	endfunction

	// About half of the gaps are zero and most of the rest are short. A few
	// gaps are long.
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [31:0] pick_target();
		int roll;
		roll = $urandom_range(0, 9);
		if (roll == 0)
			return 32'h7FFF_FFFF;
		if (roll == 1)
			return 32'h8000_0000;
		if (roll < 5)
			return $urandom_range(0, 32'h000F_FFFF) ^ ((roll == 2) ? 32'hFFFF_FFFF : 32'h0);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_step_time();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 8)
			return 32'h0;
		if (roll < 12)
			return 32'hFFFF_FFFF;
		if (roll < 52)
			return $urandom_range(1, 32'h0010_0000);
		if (roll < 82)
			return $urandom_range(32'h0010_0000, 32'h0400_0000);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_rate();
		case ($urandom_range(0, 5))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom;
			3:       return $urandom_range(1, 32'h0100_0000);
			default: return $urandom_range(32'h0001_0000, 32'h0400_0000);
		endcase
	endfunction

	function automatic logic [31:0] pick_time_constant();
		case ($urandom_range(0, 4))
			0:       return 32'h0;
			1:       return 32'hFFFF_FFFF;
			2:       return $urandom;
			default: return $urandom_range(0, 32'h0400_0000);
		endcase
	endfunction

	// Offers one item after a random gap. Junk is driven on the fields while
	// valid is low. Once the item is taken, its expected result is queued.
	task automatic send_item(input logic act, input logic [31:0] tgt, input logic [31:0] dt,
			input logic known, input logic [31:0] want);
		int          gap;
		logic [31:0] predicted;
		if (tx_calm != 0) begin
			tx_calm--;
			gap = 0;
		end else begin
			gap = pick_gap();
			if ($urandom_range(0, 63) == 0)
				tx_calm = $urandom_range(30, 120);
		end
		@(negedge clk);
		if (gap != 0) begin
			in_valid  <= 1'b0;
			action    <= 1'($urandom);
			target    <= $urandom;
			step_time <= $urandom;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		action    <= act;
		target    <= tgt;
		step_time <= dt;
		do
			@(posedge clk);
		while (in_stall);
		predicted = shape_item(act, tgt, dt);
		expected_smoothed.push_back(known ? want : predicted);
	endtask

	// Drops valid and waits until every result is back. Every item gives
	// exactly one result, so the core is idle once this returns.
	task automatic drain_block();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_smoothed.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic idx, input logic [31:0] word);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= word;
		@(posedge clk);
		if (idx == REG_SLEW_RATE)
			rate_limit = word[RATE_W-1:0];
		else
			lag_constant = word;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	// The receiver changes out_stall only on falling edges. Most of the time it
	// stalls at random. Some stretches have no stall at all, and once, on
	// request, it holds off for a long stretch so that the core backs up.
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			out_stall <= 1'b1;
		end else if (squeeze_request && !squeeze_done) begin
			squeeze_done = 1'b1;
			rx_hold      = SQUEEZE_CYCLES - 1;
			out_stall   <= 1'b1;
		end else if (rx_calm != 0) begin
			rx_calm--;
			out_stall <= 1'b0;
		end else begin
			rx_hold = pick_gap();
			if (rx_hold == 0 && $urandom_range(0, 99) == 0)
				rx_calm = $urandom_range(100, 300);
			if (rx_hold != 0) begin
				rx_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// The monitor takes a result on the same edge as the core hands it over.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (expected_smoothed.size() == 0) begin
				report_mismatch($sformatf("result %0d: smoothed %h with nothing expected",
					results_seen, smoothed));
			end else begin
				oldest_smoothed = expected_smoothed.pop_front();
				if (smoothed !== oldest_smoothed)
					report_mismatch($sformatf("result %0d: smoothed %h, expected %h",
						results_seen, smoothed, oldest_smoothed));
			end
		end
	end

	initial begin
		logic [31:0] rate_word;
		logic [31:0] lag_word;
		logic [31:0] goal;
		int          run_left;
		int          roll;
		int          spins;
		run_left = 0;
		goal     = 32'h0;
		spins    = 0;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part. Register rows wait for the core to go idle first.
		for (int i = 0; i < PLAN_ROWS; i++) begin
			if (directed_plan[i].kind == ROW_WRITE) begin
				drain_block();
				write_register(directed_plan[i].sel, directed_plan[i].span);
			end else begin
				send_item(directed_plan[i].sel, directed_plan[i].tgt, directed_plan[i].span,
					directed_plan[i].known, directed_plan[i].want);
			end
		end

		// Random phases. The first two use fixed extreme settings, the third a
		// fixed moderate one, and the rest draw new ones, weighted toward zero and full scale.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			drain_block();
			case (phase)
				0: begin
					rate_word = 32'h7FFF_FFFF;
					lag_word  = 32'h0;
				end
				1: begin
					rate_word = 32'h0;
					lag_word  = 32'hFFFF_FFFF;
				end
				2: begin
					rate_word = 32'h0001_0000;
					lag_word  = 32'h0100_0000;
				end
				default: begin
					rate_word = pick_rate();
					lag_word  = pick_time_constant();
				end
			endcase
			write_register(REG_SLEW_RATE, rate_word);
			write_register(REG_TIME_CONSTANT, lag_word);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (phase == SQUEEZE_PHASE && k == 8)
					squeeze_request = 1'b1;
				// Hold one goal over a run of steps so the ramp and both
				// stages actually settle on it.
				if (run_left == 0) begin
					goal     = pick_target();
					run_left = $urandom_range(1, 40);
				end
				run_left--;
				roll = $urandom_range(0, 99);
				if (roll < 4)
					send_item(ACT_CLEAR, $urandom, $urandom, 1'b0, 32'h0);
				else if (roll < 7)
					send_item(ACT_STEP, pick_target(), pick_step_time(), 1'b0, 32'h0);
				else
					send_item(ACT_STEP, goal, pick_step_time(), 1'b0, 32'h0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_smoothed.size() != 0 && spins < END_WAIT_LIMIT) begin
			@(posedge clk);
			spins++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_smoothed.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", expected_smoothed.size()));
		if (fail_count == 0)
			$display("tb_top: clean");
		else
			$display("tb_top: errors");
		$finish;
	end

endmodule

// ===== s_curve_trajectory_planner_core.f =====
hw/rtl/sctp_pkg.sv
hw/rtl/sctp_div.sv
hw/rtl/s_curve_trajectory_planner_core.sv
dv/tb_top.sv
